// ----- rtl/core/awsc_pkg.sv -----
`default_nettype none

package awsc_pkg;

  // default number of entries (one cell per entry)
  localparam int unsigned DEPTH_DEF = 256;

  localparam int unsigned WORD_W = 32;

  // operation codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // transaction as it travels down the cell chain
  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] wval;
    logic              hit;
    logic [WORD_W-1:0] rdata;
  } query_t;

endpackage

`default_nettype wire

// ----- rtl/core/awsc_cell.sv -----
`default_nettype none

module awsc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            vld_in,
  input  wire awsc_pkg::query_t q_in,
  output logic                 vld_out,
  output awsc_pkg::query_t     q_out
);
  import awsc_pkg::*;

  logic              occ_r;
  logic              occ_nxt;
  logic [WORD_W-1:0] key_r;
  logic [WORD_W-1:0] key_nxt;
  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              vld_r;
  query_t            q_r;
  query_t            q_nxt;
  logic              match;
  logic              claim;

  // compare against the held entry, or let a store take this empty cell for a new key
  assign match = vld_in && occ_r && !q_in.hit && (key_r == q_in.addr);
  assign claim = vld_in && !occ_r && !q_in.hit && (q_in.func == FUNC_STORE);

  // entry update and transaction update
  always_comb begin
    occ_nxt  = occ_r;
    key_nxt  = key_r;
    data_nxt = data_r;
    q_nxt    = q_in;
    if (claim) begin
      occ_nxt   = 1'b1;
      key_nxt   = q_in.addr;
      data_nxt  = q_in.wval;
      q_nxt.hit = 1'b1;
    end else if (match) begin
      q_nxt.hit = 1'b1;
      if (q_in.func == FUNC_STORE) begin
        data_nxt = q_in.wval;
      end else begin
        q_nxt.rdata = data_r;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      vld_r <= 1'b0;
    end else if (adv) begin
      occ_r <= occ_nxt;
      vld_r <= vld_in;
    end
  end

  // entry and pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      key_r  <= key_nxt;
      data_r <= data_nxt;
      q_r    <= q_nxt;
    end
  end

  assign vld_out = vld_r;
  assign q_out   = q_r;

endmodule

`default_nettype wire

// ----- rtl/core/associative_word_store_core.sv -----
`default_nettype none

// channel | ports                                        | direction
// in      | in_valid, in_ready, in_func, in_address,     | into block
//         | in_write_value                               |
// out     | out_valid, out_ready, out_read_value,        | out of block
//         | out_status                                   |
//
// one transaction is accepted per cycle unless the chain is stalled; each passes
// one cell per cycle, through the DEPTH cell registers and then the output register
// entries fill cell 0 upward in insertion order; results keep input order
// reset empties every cell at once (no clearing pass)
// a stalled output register freezes the whole chain and drops in_ready

module associative_word_store_core #(
  parameter int unsigned DEPTH = awsc_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_address,
  input  wire logic signed [31:0] in_write_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_read_value,
  output logic [1:0]              out_status
);
  import awsc_pkg::*;

  logic          adv;
  logic          vld_c [DEPTH+1];
  query_t        q_c   [DEPTH+1];
  logic          out_valid_r;
  logic [31:0]   read_value_r;
  logic [31:0]   read_value_nxt;
  status_t       status_r;
  status_t       status_nxt;
  query_t        q_last;

  // chain moves whenever the output register is free or being emptied
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // head of the chain
  assign vld_c[0] = in_valid;
  assign q_c[0]   = '{func: in_func, addr: in_address, wval: in_write_value,
                      hit: 1'b0, rdata: '0};

  // row of cells, one entry each
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    awsc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld_c[i]),
      .q_in    (q_c[i]),
      .vld_out (vld_c[i+1]),
      .q_out   (q_c[i+1])
    );
  end

  assign q_last = q_c[DEPTH];

  // status from what survived the chain
  always_comb begin
    read_value_nxt = q_last.rdata;
    if (q_last.hit) begin
      status_nxt = ST_OK;
    end else if (q_last.func == FUNC_STORE) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_MISS;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_c[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_value_r <= read_value_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_value_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire
